@@ design/qqbd_pkg.sv @@
// ----------------------------------------------------------------------------
// qqbd_pkg
// Shared widths, constants and stage control types for the Q4_0 x Q8_0
// block dot product core.
// ----------------------------------------------------------------------------
package qqbd_pkg;

	// Width of the packed input fields, in bytes
	localparam int FIELD_BYTES = 4;

	// One lane: two 4x8 signed products summed
	localparam int LANE_W = 13;

	// Block dot, two's complement, wraps at this width
	localparam int DOT_W = 17;

	// |dot| * half mantissa, then times the UQ8.24 activation scale
	localparam int MAG1_W  = 28;
	localparam int SCALE_W = 32;
	localparam int PROD_W  = 60;

	// Left shifts reach 13 places at most
	localparam int SHL_W = 74;

	// Row accumulator, signed Q31.32
	localparam int ACC_W = 64;

	// Half-precision fields
	localparam int HALF_W = 16;
	localparam int EXP_W  = 5;
	localparam int MANT_W = 11;

	localparam logic [EXP_W-1:0] EXP_INF = 5'd31;
	// Exponent at which the exact product needs no shift into Q31.32
	localparam logic [EXP_W-1:0] EXP_POINT = 5'd17;

	localparam logic [ACC_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] NEG_MAX = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic valid;
		logic close;
		logic last_row;
	} item_ctrl_t;

	typedef struct packed {
		logic valid;
		logic last_row;
		logic force_sat;
		logic neg;
	} term_ctrl_t;

endpackage

@@ design/qqbd_lane.sv @@
// ----------------------------------------------------------------------------
// qqbd_lane
// One byte lane: both 4-bit weights of a packed byte times their int8
// activations, summed.
// ----------------------------------------------------------------------------
module qqbd_lane import qqbd_pkg::*; (
	input  logic [7:0]               weight_byte,
	input  logic [7:0]               act_lo,
	input  logic [7:0]               act_hi,
	output logic signed [LANE_W-1:0] lane_sum
);

	logic signed [3:0]  w_lo;
	logic signed [3:0]  w_hi;
	logic signed [11:0] p_lo;
	logic signed [11:0] p_hi;

	// nibble minus 8 is the nibble with its top bit flipped
	assign w_lo = {~weight_byte[3], weight_byte[2:0]};
	assign w_hi = {~weight_byte[7], weight_byte[6:4]};

	assign p_lo = 12'(w_lo) * 12'($signed(act_lo));
	assign p_hi = 12'(w_hi) * 12'($signed(act_hi));

	assign lane_sum = LANE_W'(p_lo) + LANE_W'(p_hi);

endmodule

@@ design/qqbd_merge.sv @@
// ----------------------------------------------------------------------------
// qqbd_merge
// Merge stage: adds the lane sums of one item and registers the item dot.
// ----------------------------------------------------------------------------
module qqbd_merge import qqbd_pkg::*; #(
	parameter int LANES = 4
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [LANE_W-1:0] lane_sum [LANES],
	output logic [DOT_W-1:0]         item_sum_s1
);

	logic [DOT_W-1:0] item_sum;

	// wraps at the block dot width, as the block dot itself does
	always_comb begin
		item_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			item_sum = item_sum + DOT_W'(lane_sum[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_sum_s1 <= item_sum;
		end
	end

endmodule

@@ design/qqbd_scale.sv @@
// ----------------------------------------------------------------------------
// qqbd_scale
// Block close pipeline: decodes the fp16 weight scale, forms
// |dot| * mantissa * act_scale exactly over two multiplier stages, then
// shifts into Q31.32 with round half away from zero or saturates.
// ----------------------------------------------------------------------------
module qqbd_scale import qqbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  item_ctrl_t         ctrl_in,
	input  logic [DOT_W-1:0]   dot_in,
	input  logic [HALF_W-1:0]  half_in,
	input  logic [SCALE_W-1:0] scale_in,
	output term_ctrl_t         ctrl_out,
	output logic [ACC_W-1:0]   term_out
);

	// s2: captured block dot and scales
	item_ctrl_t         ctrl_s2;
	logic [DOT_W-1:0]   dot_s2;
	logic [HALF_W-1:0]  half_s2;
	logic [SCALE_W-1:0] scale_s2;

	// s3: decoded, first product
	logic               valid_s3, last_row_s3;
	logic               neg_s3, inf_s3, zero_s3;
	logic [EXP_W-1:0]   exp_s3;
	logic [MAG1_W-1:0]  mag1_s3;
	logic [SCALE_W-1:0] scale_s3;

	// s4: full product
	logic               valid_s4, last_row_s4;
	logic               neg_s4, inf_s4, zero_s4;
	logic [EXP_W-1:0]   exp_s4;
	logic [PROD_W-1:0]  p_s4;

	// decode
	logic               dneg;
	logic [DOT_W-1:0]   dmag;
	logic [EXP_W-1:0]   exp_raw;
	logic [EXP_W-1:0]   exp_eff;
	logic [MANT_W-1:0]  mant;
	logic               kill, inf, zero;

	// shift and round
	logic [EXP_W-1:0]   rsh;
	logic [EXP_W-1:0]   lsh;
	logic [PROD_W:0]    rnd;
	logic [SHL_W-1:0]   shl;
	logic [ACC_W-1:0]   mag;
	logic               ovf;

	always_comb begin
		dneg    = dot_s2[DOT_W-1];
		dmag    = dneg ? (DOT_W'(0) - dot_s2) : dot_s2;
		exp_raw = half_s2[14:10];
		exp_eff = (exp_raw == '0) ? EXP_W'(1) : exp_raw;
		mant    = {(exp_raw != '0), half_s2[9:0]};
		kill    = !ctrl_s2.close || (dmag == '0) || (scale_s2 == '0);
		inf     = !kill && (exp_raw == EXP_INF);
		zero    = kill || (!inf && (mant == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2     <= '0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			ctrl_out    <= '0;
		end else if (adv) begin
			ctrl_s2     <= ctrl_in;
			valid_s3    <= ctrl_s2.valid;
			valid_s4    <= valid_s3;
			ctrl_out.valid     <= valid_s4;
			ctrl_out.last_row  <= last_row_s4;
			ctrl_out.force_sat <= inf_s4 || (!zero_s4 && ovf);
			ctrl_out.neg       <= neg_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s2      <= dot_in;
			half_s2     <= half_in;
			scale_s2    <= scale_in;

			last_row_s3 <= ctrl_s2.last_row;
			neg_s3      <= dneg ^ half_s2[HALF_W-1];
			inf_s3      <= inf;
			zero_s3     <= zero;
			exp_s3      <= exp_eff;
			mag1_s3     <= MAG1_W'(dmag) * MAG1_W'(mant);
			scale_s3    <= scale_s2;

			last_row_s4 <= last_row_s3;
			neg_s4      <= neg_s3;
			inf_s4      <= inf_s3;
			zero_s4     <= zero_s3;
			exp_s4      <= exp_s3;
			p_s4        <= PROD_W'(mag1_s3) * PROD_W'(scale_s3);

			term_out    <= zero_s4 ? '0 : (neg_s4 ? (ACC_W'(0) - mag) : mag);
		end
	end

	// below the binary point exponent: round right shift of 1..16 places;
	// at or above it: left shift of 0..13 places with a range check
	always_comb begin
		rsh = EXP_POINT - exp_s4;
		lsh = exp_s4 - EXP_POINT;
		rnd = '0;
		shl = '0;
		ovf = 1'b0;
		if (exp_s4 < EXP_POINT) begin
			rnd = ((PROD_W+1)'(p_s4) + ((PROD_W+1)'(1) << (rsh - EXP_W'(1)))) >> rsh;
			mag = ACC_W'(rnd);
		end else begin
			shl = SHL_W'(p_s4) << lsh;
			mag = shl[ACC_W-1:0];
			if (neg_s4) begin
				ovf = (shl[SHL_W-1:ACC_W] != '0) ||
					(shl[ACC_W-1] && (shl[ACC_W-2:0] != '0));
			end else begin
				ovf = (shl[SHL_W-1:ACC_W-1] != '0);
			end
		end
	end

endmodule

@@ design/qqbd_acc.sv @@
// ----------------------------------------------------------------------------
// qqbd_acc
// Row accumulator with saturating add, sticky saturation flag and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module qqbd_acc import qqbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  term_ctrl_t       ctrl_in,
	input  logic [ACC_W-1:0] term_in,
	input  logic             out_stall,
	output logic             busy,
	output logic             out_valid,
	output logic [ACC_W-1:0] row_sum_q,
	output logic             overflow_q
);

	logic [ACC_W-1:0] row_acc_q;
	logic             sat_q;
	logic             out_valid_q;
	logic [ACC_W-1:0] sum;
	logic             add_ovf;
	logic [ACC_W-1:0] acc_next;
	logic             sat_next;

	always_comb begin
		sum     = row_acc_q + term_in;
		add_ovf = ((row_acc_q[ACC_W-1] ^ sum[ACC_W-1]) &
			(term_in[ACC_W-1] ^ sum[ACC_W-1]));
		if (ctrl_in.force_sat) begin
			acc_next = ctrl_in.neg ? NEG_MAX : POS_MAX;
			sat_next = 1'b1;
		end else if (add_ovf) begin
			acc_next = row_acc_q[ACC_W-1] ? NEG_MAX : POS_MAX;
			sat_next = 1'b1;
		end else begin
			acc_next = sum;
			sat_next = sat_q;
		end
	end

	// hold the pipeline while a row result waits behind an untaken one
	assign busy      = ctrl_in.valid && ctrl_in.last_row && out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_acc_q   <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new row result replaces one taken in the same cycle
			if (adv && ctrl_in.valid && ctrl_in.last_row) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv && ctrl_in.valid) begin
				if (ctrl_in.last_row) begin
					row_acc_q   <= '0;
					sat_q       <= 1'b0;
				end else begin
					row_acc_q   <= acc_next;
					sat_q       <= sat_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_in.valid && ctrl_in.last_row) begin
			row_sum_q  <= acc_next;
			overflow_q <= sat_next;
		end
	end

endmodule

@@ design/q4_q8_block_dot_core.sv @@
// ----------------------------------------------------------------------------
// q4_q8_block_dot_core
// Streaming Q4_0 weight x Q8_0 activation row dot product, one quarter
// block per input transfer, signed Q31.32 row sum out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one quarter of a 32-element block
//   per transfer. Mark the fourth quarter with last_in_block; weight_scale
//   and act_scale are taken from that transfer. Mark the final transfer of
//   a row with last_in_row.
//   Output channel (out_valid / out_stall): one transfer per row, carrying
//   row_sum and the sticky overflow flag for that row.
//   Throughput: one input transfer per cycle while in_stall is low, set by the
//   byte lanes working side by side on all packed bytes of a transfer.
//   Path: the row result is registered through merge, block-dot, decode
//   with the first multiplier, the second multiplier, shift/round and
//   the accumulate stage.
//   Stall: a waiting result does not block further input until the next
//   row result reaches the accumulate stage; then the whole pipeline holds
//   and in_stall is raised until the output transfer takes place.
//   Reset: clears the block dot, row accumulator, flag and all valid bits.
// ----------------------------------------------------------------------------
module q4_q8_block_dot_core import qqbd_pkg::*; #(
	parameter int BYTES_PER_ITEM = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [31:0]              weight_bytes,
	input  logic [31:0]              act_low,
	input  logic [31:0]              act_high,
	input  logic [HALF_W-1:0]        weight_scale,
	input  logic [SCALE_W-1:0]       act_scale,
	input  logic                     last_in_block,
	input  logic                     last_in_row,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ACC_W-1:0]  row_sum,
	output logic                     overflow
);

	logic                     adv;
	logic                     acc_busy;
	logic signed [LANE_W-1:0] lane_sum [BYTES_PER_ITEM];
	logic [DOT_W-1:0]         item_sum_s1;
	item_ctrl_t               ctrl_s1;
	logic [HALF_W-1:0]        half_s1;
	logic [SCALE_W-1:0]       scale_s1;
	logic [DOT_W-1:0]         block_dot_q;
	logic [DOT_W-1:0]         dot_next;
	term_ctrl_t               term_ctrl;
	logic [ACC_W-1:0]         term;
	logic [ACC_W-1:0]         row_sum_q;

	assign adv      = !acc_busy;
	assign in_stall = !adv;

	genvar j;
	generate
		for (j = 0; j < BYTES_PER_ITEM; j++) begin : g_lane
			if (j < FIELD_BYTES) begin : g_live
				qqbd_lane u_lane (
					.weight_byte (weight_bytes[8*j +: 8]),
					.act_lo      (act_low[8*j +: 8]),
					.act_hi      (act_high[8*j +: 8]),
					.lane_sum    (lane_sum[j])
				);
			end else begin : g_pad
				// bytes past the packed fields contribute nothing
				assign lane_sum[j] = '0;
			end
		end
	endgenerate

	qqbd_merge #(
		.LANES (BYTES_PER_ITEM)
	) u_merge (
		.clk         (clk),
		.adv         (adv),
		.lane_sum    (lane_sum),
		.item_sum_s1 (item_sum_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1     <= '0;
			block_dot_q <= '0;
		end else if (adv) begin
			ctrl_s1.valid    <= in_valid;
			ctrl_s1.close    <= last_in_block;
			ctrl_s1.last_row <= last_in_row;
			// drop the running dot at block end, and a partial block at row end
			if (ctrl_s1.valid) begin
				block_dot_q <= (ctrl_s1.close || ctrl_s1.last_row) ? '0 : dot_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s1  <= weight_scale;
			scale_s1 <= act_scale;
		end
	end

	assign dot_next = block_dot_q + item_sum_s1;

	qqbd_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctrl_in  (ctrl_s1),
		.dot_in   (dot_next),
		.half_in  (half_s1),
		.scale_in (scale_s1),
		.ctrl_out (term_ctrl),
		.term_out (term)
	);

	qqbd_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctrl_in    (term_ctrl),
		.term_in    (term),
		.out_stall  (out_stall),
		.busy       (acc_busy),
		.out_valid  (out_valid),
		.row_sum_q  (row_sum_q),
		.overflow_q (overflow)
	);

	assign row_sum = $signed(row_sum_q);

endmodule

@@ design/qqbd_checker.sv @@
// ----------------------------------------------------------------------------
// qqbd_checker
// Port-level checks on the block dot core, attached by bind.
// ----------------------------------------------------------------------------
module qqbd_checker import qqbd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [ACC_W-1:0] row_sum,
	input logic                    overflow
);

	// a result that is not taken stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_sum) && $stable(overflow))
		else $error("stalled result changed or dropped");

	// input back-pressure only comes from a waiting result
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no result waiting");

	a_stall_needs_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// a new result is loaded only on a cycle the pipeline advanced
	a_load_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("result appeared while pipeline was held");

endmodule

bind q4_q8_block_dot_core qqbd_checker u_qqbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_sum   (row_sum),
	.overflow  (overflow)
);

@@ dv/tb_q4_q8_block_dot_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q4_q8_block_dot_core
// Self-checking bench for the Q4_0 x Q8_0 streaming row dot product core.
// Quarter blocks are driven from a queue, each accepted transfer runs through
// a bit-exact predictor of the block dot, fp16 x UQ8.24 scaling and the
// saturating Q31.32 row accumulator, and every row result is compared with
// the oldest predicted row. Directed corner rows come first, then random
// well-formed rows with some stray quarters, under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_q4_q8_block_dot_core;
	import qqbd_pkg::*;

	localparam int RANDOM_ITEMS = 900;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [31:0] wts;
		logic [31:0] alo;
		logic [31:0] ahi;
		logic [15:0] wscale;
		logic [31:0] ascale;
		logic        lb;
		logic        lr;
	} quarter_t;

	typedef struct {
		logic [63:0] sum;
		logic        ovf;
	} row_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] weight_bytes = '0;
	logic [31:0] act_low = '0;
	logic [31:0] act_high = '0;
	logic [HALF_W-1:0] weight_scale = '0;
	logic [SCALE_W-1:0] act_scale = '0;
	logic last_in_block = 1'b0;
	logic last_in_row = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ACC_W-1:0] row_sum;
	logic overflow;

	quarter_t    quarter_q[$];
	row_result_t pending_rows[$];

	// predictor state
	logic [16:0] dot_run = '0;
	logic [63:0] row_total = '0;
	logic        row_clipped = 1'b0;

	int sent_count = 0;
	int total_items = 0;
	int errors = 0;
	int quiet = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	q4_q8_block_dot_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.weight_bytes (weight_bytes),
		.act_low      (act_low),
		.act_high     (act_high),
		.weight_scale (weight_scale),
		.act_scale    (act_scale),
		.last_in_block(last_in_block),
		.last_in_row  (last_in_row),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_sum      (row_sum),
		.overflow     (overflow)
	);

	always #4 clk = ~clk;

	// Idle percentage for the current stretch of the run.
	function automatic int idle_pct(input bit sender);
		int stage;
		stage = (sent_count * 3) / ((total_items > 0) ? total_items : 1);
		if (stage == 0)
			return sender ? 35 : 79;
		if (stage == 1)
			return sender ? 79 : 35;
		return 0;
	endfunction

	// Fold one accepted quarter into the block dot, close the block and row as marked.
	task automatic accumulate_quarter(input quarter_t q);
		int lane_sum;
		int j;
		int sh;
		logic signed [7:0] xl;
		logic signed [7:0] xh;
		logic [16:0] dot;
		logic [4:0] ex;
		logic dneg;
		logic neg;
		logic clip;
		logic [63:0] dmag;
		logic [63:0] mant;
		logic [63:0] p;
		logic [63:0] lim;
		logic [63:0] term;
		logic [63:0] s;
		lane_sum = 0;
		for (j = 0; j < 4; j++) begin
			xl = q.alo[8*j +: 8];
			xh = q.ahi[8*j +: 8];
			lane_sum += (int'(q.wts[8*j +: 4]) - 8) * xl;
			lane_sum += (int'(q.wts[8*j+4 +: 4]) - 8) * xh;
		end
		dot_run = dot_run + lane_sum[16:0];
		if (q.lb) begin
			dot = dot_run;
			dot_run = '0;
			dneg = dot[16];
			dmag = dneg ? (64'h20000 - {47'd0, dot}) : {47'd0, dot};
			ex = q.wscale[14:10];
			neg = dneg ^ q.wscale[15];
			mant = (ex != 0) ? {53'd0, 1'b1, q.wscale[9:0]} : {54'd0, q.wscale[9:0]};
			clip = 1'b0;
			p = '0;
			if (dmag != 0 && q.ascale != 0) begin
				if (ex == EXP_INF) begin
					clip = 1'b1;
				end else if (mant != 0) begin
					p = dmag * mant * {32'd0, q.ascale};
					sh = ((ex != 0) ? int'(ex) : 1) - int'(EXP_POINT);
					if (sh < 0) begin
						// round half away from zero on the magnitude
						p = (p + (64'd1 << (-sh - 1))) >> (-sh);
					end else begin
						lim = neg ? NEG_MAX : POS_MAX;
						if (p > (lim >> sh))
							clip = 1'b1;
						else
							p = p << sh;
					end
				end
			end
			if (clip) begin
				row_total = neg ? NEG_MAX : POS_MAX;
				row_clipped = 1'b1;
			end else if (p != 0) begin
				term = neg ? (64'd0 - p) : p;
				s = row_total + term;
				if (row_total[63] == term[63] && s[63] != row_total[63]) begin
					s = row_total[63] ? NEG_MAX : POS_MAX;
					row_clipped = 1'b1;
				end
				row_total = s;
			end
		end
		if (q.lr) begin
			pending_rows.push_back('{row_total, row_clipped});
			row_total = '0;
			row_clipped = 1'b0;
			dot_run = '0;
		end
	endtask

	task automatic push_quarter(input logic [31:0] w, input logic [31:0] lo,
			input logic [31:0] hi, input logic [15:0] ws, input logic [31:0] as,
			input logic lb, input logic lr);
		quarter_q.push_back('{w, lo, hi, ws, as, lb, lr});
	endtask

	function automatic quarter_t random_quarter();
		quarter_t q;
		q.wts = $urandom;
		q.alo = ($urandom_range(7) == 0) ? 32'h8080_8080 : $urandom;
		q.ahi = ($urandom_range(7) == 0) ? 32'h7F7F_7F7F : $urandom;
		case ($urandom_range(9))
			0: q.wscale = 16'($urandom);
			1: q.wscale = {1'($urandom), 5'd0, 10'($urandom)};
			2: q.wscale = {1'($urandom), EXP_INF, 10'($urandom)};
			3: q.wscale = {1'($urandom), 15'd0};
			default: q.wscale = {1'($urandom), 5'($urandom_range(18, 6)), 10'($urandom)};
		endcase
		case ($urandom_range(7))
			0: q.ascale = '0;
			1: q.ascale = $urandom;
			default: q.ascale = $urandom_range(32'h0200_0000, 32'h0008_0000);
		endcase
		q.lb = 1'b0;
		q.lr = 1'b0;
		return q;
	endfunction

	// Driver: present the next quarter once the previous transfer is done.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				accumulate_quarter('{weight_bytes, act_low, act_high, weight_scale,
					act_scale, last_in_block, last_in_row});
				sent_count <= sent_count + 1;
			end
			if (!in_valid || !in_stall) begin
				if (quarter_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					weight_bytes  <= quarter_q[0].wts;
					act_low       <= quarter_q[0].alo;
					act_high      <= quarter_q[0].ahi;
					weight_scale  <= quarter_q[0].wscale;
					act_scale     <= quarter_q[0].ascale;
					last_in_block <= quarter_q[0].lb;
					last_in_row   <= quarter_q[0].lr;
					in_valid      <= 1'b1;
					void'(quarter_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold once the idle-free stretch starts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && idle_pct(1'b0) == 0 && total_items > 0) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct(1'b0));
			end
		end
	end

	// Monitor: compare each row transfer with the oldest predicted row.
	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row: expected none, actual row_sum %h overflow %b",
					$time, row_sum, overflow);
				errors = errors + 1;
			end else begin
				want = pending_rows.pop_front();
				if (row_sum !== want.sum) begin
					$display("%0t: row_sum mismatch: expected %h, actual %h",
						$time, want.sum, row_sum);
					errors = errors + 1;
				end
				if (overflow !== want.ovf) begin
					$display("%0t: overflow mismatch: expected %b, actual %b",
						$time, want.ovf, overflow);
					errors = errors + 1;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("** q4_q8_block_dot_core: FAILED **");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		quarter_t q;
		int nblk;
		int b;
		int k;

		// one block of maximum positive dot at unit scales, kept open in the row
		for (k = 0; k < 4; k++)
			push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'h3C00, 32'h0100_0000,
				k == 3, 1'b0);
		// all nibbles +7 against both activation extremes, negative scale, full act scale
		push_quarter(32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h8080_8080, 16'hBC00, 32'hFFFF_FFFF,
			1'b1, 1'b1);
		// subnormal half, tiny scale that rounds away, then a large one
		push_quarter(32'h9999_9999, 32'h0101_0101, 32'h0101_0101, 16'h0001, 32'h0000_0001,
			1'b1, 1'b0);
		push_quarter(32'h9999_9999, 32'h0101_0101, 32'h0101_0101, 16'h83FF, 32'hFFFF_FFFF,
			1'b1, 1'b0);
		// half zero, then infinity with act scale zero: both add nothing
		push_quarter(32'h9999_9999, 32'h0101_0101, 32'h0101_0101, 16'h8000, 32'h0100_0000,
			1'b1, 1'b0);
		push_quarter(32'h9999_9999, 32'h0101_0101, 32'h0101_0101, 16'h7C00, 32'h0, 1'b1, 1'b0);
		// negative NaN closes the row saturated
		push_quarter(32'h9999_9999, 32'h0101_0101, 32'h0101_0101, 16'hFE00, 32'h0100_0000,
			1'b1, 1'b1);
		// block left open for eight quarters: dot wraps to the most negative value
		for (k = 0; k < 8; k++)
			push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'h3C00, 32'h0100_0000,
				k == 7, k == 7);
		// largest finite half at full act scale: term too large
		push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'h7BFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// two terms of 2^62 overflow the accumulator upward; two of -2^62 just reach its most negative value
		push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'h6400, 32'h8000_0000, 1'b1, 1'b0);
		push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'h6400, 32'h8000_0000, 1'b1, 1'b1);
		push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'hE400, 32'h8000_0000, 1'b1, 1'b0);
		push_quarter(32'h0, 32'h8080_8080, 32'h8080_8080, 16'hE400, 32'h8000_0000, 1'b1, 1'b1);
		// row closed mid block: partial dot dropped
		push_quarter(32'h1234_5678, 32'h7F80_017F, 32'hFF00_80AA, 16'h3C00, 32'h0100_0000,
			1'b0, 1'b1);

		// random rows of whole blocks, with stray quarters as noise
		while (quarter_q.size() < RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				q = random_quarter();
				q.lb = 1'($urandom);
				q.lr = ($urandom_range(3) == 0);
				quarter_q.push_back(q);
			end else begin
				nblk = $urandom_range(4, 1);
				for (b = 0; b < nblk; b++) begin
					for (k = 0; k < 4; k++) begin
						q = random_quarter();
						q.lb = (k == 3);
						q.lr = (k == 3 && b == nblk - 1);
						quarter_q.push_back(q);
					end
				end
			end
		end
		total_items = quarter_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (quarter_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending_rows.size() == 0) begin
			$display("** q4_q8_block_dot_core: PASSED **");
		end else begin
			$display("** q4_q8_block_dot_core: FAILED **");
		end
		$finish;
	end

endmodule
